### sv/tgad_pkg.sv
`timescale 1ns / 1ps

package tgad_pkg;

    // One byte of the incoming file.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in_item;

    // One decoded pixel run, or a status report.
    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  run_length;
        logic [1:0]  pixel_format;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  status;
        logic        image_done;
    } t_out_item;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ID_CMAP   = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    // Image types that are accepted.
    localparam logic [7:0] TYPE_RAW = 8'd2;
    localparam logic [7:0] TYPE_RLE = 8'd10;

    // Header byte positions that carry fields.
    localparam logic [4:0] HB_ID_LEN    = 5'd0;
    localparam logic [4:0] HB_CMAP_TYPE = 5'd1;
    localparam logic [4:0] HB_IMG_TYPE  = 5'd2;
    localparam logic [4:0] HB_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HB_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HB_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HB_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HB_BPP       = 5'd16;
    localparam logic [4:0] HB_LAST      = 5'd17;

endpackage

### sv/tgad_in_reg.sv
`timescale 1ns / 1ps

module tgad_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tgad_pkg::t_in_item i_in_data,
    input  logic              i_advance,
    output logic              o_step,
    output tgad_pkg::t_in_item o_item
);
    import tgad_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // The held byte is processed whenever the result side can move.
    assign o_step     = r_valid && i_advance;
    assign o_in_ready = !r_valid || i_advance;
    assign o_item     = r_item;

    // Capture a new transaction, or empty the register once its byte is used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (o_step) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_data;
        end
    end

endmodule

### sv/tgad_core.sv
`timescale 1ns / 1ps

module tgad_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  tgad_pkg::t_in_item  i_item,
    output logic                o_res_valid,
    output tgad_pkg::t_out_item o_res
);
    import tgad_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PACKET,
        PH_PIXEL,
        PH_DRAIN
    } t_phase;

    t_phase      r_phase,   n_phase;
    logic [4:0]  r_hdr_idx, n_hdr_idx;
    logic [15:0] r_width,   n_width;
    logic [15:0] r_height,  n_height;
    logic [7:0]  r_type,    n_type;
    logic [7:0]  r_bpp,     n_bpp;
    logic [7:0]  r_idlen,   n_idlen;
    logic [7:0]  r_cmap,    n_cmap;
    logic [31:0] r_pix_rem, n_pix_rem;
    logic [7:0]  r_pkt_rem, n_pkt_rem;
    logic        r_pkt_rep, n_pkt_rep;
    logic [31:0] r_asm,     n_asm;
    logic [1:0]  r_pix_idx, n_pix_idx;

    logic [7:0]  b;
    logic        eof;
    logic [4:0]  chans;
    logic [4:0]  n_chans;
    logic [31:0] cur_asm;
    logic [31:0] pix;
    logic [7:0]  run;
    logic        compressed;
    logic [2:0]  hdr_status;

    logic        res_valid;
    logic [31:0] res_pix;
    logic [7:0]  res_run;
    logic [2:0]  res_status;
    logic        res_done;

    // Channel reorder: swap B and R, or turn A1RGB5 into RGB5A1.
    function automatic logic [31:0] reorder(input logic [31:0] a, input logic [4:0] c);
        logic [31:0] r;
        if (c == 5'd2) begin
            r = {16'd0, a[14:0], a[15]};
        end else begin
            r = {a[31:24], a[7:0], a[15:8], a[23:16]};
        end
        return r;
    endfunction

    assign b       = i_item.data_byte;
    assign eof     = i_item.end_of_file;
    assign chans   = r_bpp[7:3];
    assign n_chans = n_bpp[7:3];

    // Decode one byte against the current phase.
    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_width    = r_width;
        n_height   = r_height;
        n_type     = r_type;
        n_bpp      = r_bpp;
        n_idlen    = r_idlen;
        n_cmap     = r_cmap;
        n_pix_rem  = r_pix_rem;
        n_pkt_rem  = r_pkt_rem;
        n_pkt_rep  = r_pkt_rep;
        n_asm      = r_asm;
        n_pix_idx  = r_pix_idx;
        res_valid  = 1'b0;
        res_pix    = 32'd0;
        res_run    = 8'd0;
        res_status = ST_OK;
        res_done   = 1'b0;
        cur_asm    = r_asm;
        pix        = 32'd0;
        run        = 8'd1;
        compressed = (r_type == TYPE_RLE);
        hdr_status = ST_OK;

        case (r_phase)
            PH_HEADER: begin
                // Collect the header fields; the first byte starts a fresh header.
                case (r_hdr_idx)
                    HB_ID_LEN: begin
                        n_idlen  = b;
                        n_cmap   = 8'd0;
                        n_type   = 8'd0;
                        n_width  = 16'd0;
                        n_height = 16'd0;
                        n_bpp    = 8'd0;
                    end
                    HB_CMAP_TYPE: n_cmap = b;
                    HB_IMG_TYPE:  n_type = b;
                    HB_WIDTH_LO:  n_width[7:0] = b;
                    HB_WIDTH_HI:  n_width[15:8] = b;
                    HB_HEIGHT_LO: n_height[7:0] = b;
                    HB_HEIGHT_HI: n_height[15:8] = b;
                    HB_BPP:       n_bpp = b;
                    default: ;
                endcase

                if (r_hdr_idx != HB_LAST) begin
                    n_hdr_idx = r_hdr_idx + 5'd1;
                    if (eof) begin
                        n_hdr_idx  = 5'd0;
                        res_valid  = 1'b1;
                        res_status = ST_TRUNC;
                        res_done   = 1'b1;
                    end
                end else begin
                    n_hdr_idx = 5'd0;
                    if (r_idlen != 8'd0 || r_cmap != 8'd0) begin
                        hdr_status = ST_ID_CMAP;
                    end else if (r_type != TYPE_RAW && r_type != TYPE_RLE) begin
                        hdr_status = ST_BAD_TYPE;
                    end else if (chans < 5'd2 || chans > 5'd4) begin
                        hdr_status = ST_BAD_DEPTH;
                    end

                    if (hdr_status != ST_OK) begin
                        n_phase    = eof ? PH_HEADER : PH_DRAIN;
                        res_valid  = 1'b1;
                        res_status = hdr_status;
                        res_done   = 1'b1;
                    end else begin
                        n_pix_rem = {16'd0, r_width} * {16'd0, r_height};
                        n_pkt_rem = 8'd0;
                        n_pkt_rep = 1'b0;
                        n_asm     = 32'd0;
                        n_pix_idx = 2'd0;
                        if (r_width == 16'd0 || r_height == 16'd0) begin
                            // Empty image: report completion at once.
                            n_phase   = eof ? PH_HEADER : PH_DRAIN;
                            res_valid = 1'b1;
                            res_done  = 1'b1;
                        end else begin
                            n_phase = compressed ? PH_PACKET : PH_PIXEL;
                            if (eof) begin
                                n_phase    = PH_HEADER;
                                res_valid  = 1'b1;
                                res_status = ST_TRUNC;
                                res_done   = 1'b1;
                            end
                        end
                    end
                end
            end

            PH_PACKET: begin
                // Packet header: repeat flag and count minus one.
                n_pkt_rep = b[7];
                n_pkt_rem = {1'b0, b[6:0]} + 8'd1;
                n_asm     = 32'd0;
                n_pix_idx = 2'd0;
                n_phase   = PH_PIXEL;
                if (eof) begin
                    n_phase    = PH_HEADER;
                    res_valid  = 1'b1;
                    res_status = ST_TRUNC;
                    res_done   = 1'b1;
                end
            end

            PH_PIXEL: begin
                cur_asm[{r_pix_idx, 3'b000} +: 8] = b;
                if ({3'd0, r_pix_idx} + 5'd1 < chans) begin
                    n_asm     = cur_asm;
                    n_pix_idx = r_pix_idx + 2'd1;
                    if (eof) begin
                        n_phase    = PH_HEADER;
                        res_valid  = 1'b1;
                        res_status = ST_TRUNC;
                        res_done   = 1'b1;
                    end
                end else begin
                    n_pix_idx = 2'd0;
                    n_asm     = 32'd0;
                    pix       = reorder(cur_asm, chans);

                    // A repeat run is clamped to the pixels left in the image.
                    if (compressed && r_pkt_rep) begin
                        run = (r_pix_rem < {24'd0, r_pkt_rem}) ? r_pix_rem[7:0] : r_pkt_rem;
                        n_pkt_rem = 8'd0;
                    end else begin
                        run = 8'd1;
                        if (r_pkt_rem != 8'd0) begin
                            n_pkt_rem = r_pkt_rem - 8'd1;
                        end
                    end
                    n_pix_rem = r_pix_rem - {24'd0, run};

                    res_valid = 1'b1;
                    res_pix   = pix;
                    res_run   = run;
                    if (n_pix_rem == 32'd0) begin
                        n_phase  = eof ? PH_HEADER : PH_DRAIN;
                        res_done = 1'b1;
                    end else begin
                        if (compressed && n_pkt_rem == 8'd0) begin
                            n_phase = PH_PACKET;
                        end
                        if (eof) begin
                            n_phase    = PH_HEADER;
                            res_status = ST_TRUNC;
                            res_done   = 1'b1;
                        end
                    end
                end
            end

            PH_DRAIN: begin
                // Skip trailing bytes until the end of the file.
                if (eof) begin
                    n_phase = PH_HEADER;
                end
            end

            default: begin
                n_phase = PH_HEADER;
            end
        endcase
    end

    // The result carries the header fields as they stand after this byte.
    always_comb begin
        o_res_valid        = i_step && res_valid;
        o_res.pixel_value  = res_pix;
        o_res.run_length   = res_run;
        o_res.pixel_format = (n_chans >= 5'd2 && n_chans <= 5'd4) ?
                             2'(n_chans - 5'd2) : 2'd0;
        o_res.image_width  = n_width;
        o_res.image_height = n_height;
        o_res.status       = res_status;
        o_res.image_done   = res_done;
    end

    // Decoder state advances only when a byte is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_idx <= 5'd0;
            r_width   <= 16'd0;
            r_height  <= 16'd0;
            r_type    <= 8'd0;
            r_bpp     <= 8'd0;
            r_idlen   <= 8'd0;
            r_cmap    <= 8'd0;
            r_pix_rem <= 32'd0;
            r_pkt_rem <= 8'd0;
            r_pkt_rep <= 1'b0;
            r_asm     <= 32'd0;
            r_pix_idx <= 2'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_width   <= n_width;
            r_height  <= n_height;
            r_type    <= n_type;
            r_bpp     <= n_bpp;
            r_idlen   <= n_idlen;
            r_cmap    <= n_cmap;
            r_pix_rem <= n_pix_rem;
            r_pkt_rem <= n_pkt_rem;
            r_pkt_rep <= n_pkt_rep;
            r_asm     <= n_asm;
            r_pix_idx <= n_pix_idx;
        end
    end

endmodule

### sv/tgad_out_reg.sv
`timescale 1ns / 1ps

module tgad_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  tgad_pkg::t_out_item i_res,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tgad_pkg::t_out_item o_out_data,
    output logic                o_advance
);
    import tgad_pkg::*;

    logic      r_valid;
    t_out_item r_data;

    // The decoder may move whenever this register is free or being emptied.
    assign o_advance   = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_res;
        end
    end

endmodule

### sv/tga_rle_pixel_decoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_in_data  (t_in_item, one file byte)
// output    out        o_out_valid / i_out_ready o_out_data (t_out_item, pixel run or status)
//
// One file byte is taken every cycle while the result register can move; a result
// passes from the input register through decode into the result register.
// The pixel count is formed by one 16x16 multiply at the last header byte.
// i_rst_n is synchronous and active low; it empties both registers and returns
// the decoder to the start of a header.
// While a result waits in the output register, the input register holds its
// byte and o_in_ready falls once that register is full.

module tga_rle_pixel_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tgad_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tgad_pkg::t_out_item o_out_data
);
    import tgad_pkg::*;

    logic      advance;
    logic      step;
    t_in_item  item;
    logic      res_valid;
    t_out_item res;

    // Input register.
    tgad_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_advance  (advance),
        .o_step     (step),
        .o_item     (item)
    );

    // Header check and packet decode.
    tgad_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    tgad_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_res       (res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_advance   (advance)
    );

endmodule
